@@ rtl/packed_2bpp_pixel_engine_unit_assert.svh @@
// Assertion macros shared by the pixel engine RTL.
`ifndef PACKED_2BPP_PIXEL_ENGINE_UNIT_ASSERT_SVH
`define PACKED_2BPP_PIXEL_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define P2PE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define P2PE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/p2pe_pkg.sv @@
// Types, constants and codes of the packed 2-bit-per-pixel engine.
package p2pe_pkg;

  localparam int FRAME_BYTES = 32768;
  localparam int GLYPH_BYTES = 4096;
  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int GA_W = $clog2(GLYPH_BYTES);
  localparam int ADDR_W = 21;

  localparam logic [7:0] KEEP_MASK [4] = '{8'hfc, 8'hf3, 8'hcf, 8'h3f};
  localparam logic [1:0] PIX_MASK = 2'h3;

  localparam logic [1:0] REG_ROW_PITCH = 2'd0;
  localparam logic [1:0] REG_GLYPH_PITCH = 2'd1;
  localparam logic [1:0] REG_XOR_MODE = 2'd2;

  typedef enum logic [2:0] {
    KIND_PLOT  = 3'd0,
    KIND_READ  = 3'd1,
    KIND_HLINE = 3'd2,
    KIND_VLINE = 3'd3,
    KIND_COPY  = 3'd4,
    KIND_GLYPH = 3'd5,
    KIND_LOAD  = 3'd6,
    KIND_NONE  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_USE,
    ST_DONE
  } state_t;

endpackage

@@ rtl/packed_2bpp_pixel_engine_unit.sv @@
// Packed 2-bit-per-pixel frame engine with glyph store and APB register port.
// A load or empty item answers in the cycle after the start transfer; a plot or read passes the
// address, read and use states. Line pixels pass them once, copy and glyph pixels up to twice.
// The pace is set by one shared multiply-add address unit and the registered memory read port.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Synchronous reset clears control state and registers; store contents are undefined until written.
module packed_2bpp_pixel_engine_unit
  import p2pe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [9:0]  x,
  input  logic [9:0]  y,
  input  logic [10:0] width,
  input  logic [10:0] height,
  input  logic [9:0]  src_x,
  input  logic [9:0]  src_y,
  input  logic [1:0]  color,
  input  logic [1:0]  bg_color,
  input  logic        use_bg,
  input  logic [11:0] glyph_addr,
  input  logic [7:0]  glyph_data,
  output logic        done,
  output logic [1:0]  pixel_value,
  output logic        out_of_range
);

`include "packed_2bpp_pixel_engine_unit_assert.svh"

  // Configuration registers; user writes them via APB only while the engine is idle, not enforced.
  logic [8:0] row_pitch;
  logic [8:0] glyph_pitch;
  logic       xor_mode;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch   <= 9'd80;
      glyph_pitch <= 9'd2;
      xor_mode    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROW_PITCH:   row_pitch <= pwdata[8:0];
        REG_GLYPH_PITCH: glyph_pitch <= pwdata[8:0];
        REG_XOR_MODE:    xor_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_PITCH:   prdata = {23'd0, row_pitch};
      REG_GLYPH_PITCH: prdata = {23'd0, glyph_pitch};
      REG_XOR_MODE:    prdata = {31'd0, xor_mode};
      default:         prdata = 32'd0;
    endcase
  end

  // Operation registers latched at the start transfer.
  state_t      state, state_next;
  kind_t       op;
  logic [9:0]  dx, dy, sx, sy;
  logic [1:0]  fg, bg;
  logic        ubg;
  logic [10:0] cnt_w, cnt_h, i, j;
  logic        src_phase;     // The current pixel is in its source read phase.
  logic [1:0]  pcol;          // Color that the destination pixel receives.
  logic [ADDR_W-1:0] addr;    // Output of the shared multiply-add unit.
  logic        flag;
  logic [1:0]  pv;

  logic        accept;
  kind_t       in_kind;
  logic [10:0] in_w, in_h;

  assign accept  = start && !busy;
  assign in_kind = kind_t'(kind);

  always_comb begin
    unique case (in_kind) inside
      KIND_HLINE:             begin in_w = width;  in_h = 11'd1;  end
      KIND_VLINE:             begin in_w = 11'd1;  in_h = height; end
      KIND_COPY, KIND_GLYPH:  begin in_w = width;  in_h = height; end
      default:                begin in_w = 11'd1;  in_h = 11'd1;  end
    endcase
  end

  // Pixel coordinates of the current step.
  logic [10:0] dcol, drow, scol, srow;
  assign dcol = {1'b0, dx} + i;
  assign drow = {1'b0, dy} + j;
  assign scol = {1'b0, sx} + i;
  assign srow = {1'b0, sy} + j;

  // The shared address unit: row times pitch plus byte offset, registered.
  logic [10:0] mul_row;
  logic [8:0]  mul_pitch, mul_off;
  logic [19:0] prod;
  logic        glyph_access;

  assign glyph_access = src_phase && (op == KIND_GLYPH);

  always_comb begin
    if (glyph_access) begin
      mul_row   = srow;
      mul_pitch = glyph_pitch;
      mul_off   = {1'b0, scol[10:3]};
    end else if (src_phase) begin
      mul_row   = srow;
      mul_pitch = row_pitch;
      mul_off   = scol[10:2];
    end else begin
      mul_row   = drow;
      mul_pitch = row_pitch;
      mul_off   = dcol[10:2];
    end
  end

  assign prod = 20'(mul_row) * 20'(mul_pitch);

  // Memories with registered read ports.
  logic [7:0] frame_mem [FRAME_BYTES];
  logic [7:0] glyph_mem [GLYPH_BYTES];
  logic [7:0] frame_rd, glyph_rd;
  logic       frame_we, glyph_we;
  logic [7:0] frame_wd;

  logic oor;
  assign oor = glyph_access ? (addr >= ADDR_W'(GLYPH_BYTES))
                            : (addr >= ADDR_W'(FRAME_BYTES));

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[addr[FA_W-1:0]] <= frame_wd;
    end
    frame_rd <= frame_mem[addr[FA_W-1:0]];
  end

  assign glyph_we = accept && (in_kind == KIND_LOAD) && (32'(glyph_addr) < GLYPH_BYTES);

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_addr[GA_W-1:0]] <= glyph_data;
    end
    glyph_rd <= glyph_mem[addr[GA_W-1:0]];
  end

  // Byte update for the destination pixel.
  logic [2:0] sh;
  logic [7:0] shifted;
  logic       use_xor;
  assign sh       = {dcol[1:0], 1'b0};
  assign shifted  = 8'(pcol) << sh;
  assign use_xor  = xor_mode && (op == KIND_PLOT || op == KIND_HLINE || op == KIND_VLINE);
  assign frame_wd = use_xor ? (frame_rd ^ shifted) : ((frame_rd & KEEP_MASK[dcol[1:0]]) | shifted);

  // Values pulled from the read data in the use step.
  logic [1:0] src_pix, dst_pix;
  logic       gbit, glyph_skip, last;
  assign src_pix    = 2'(frame_rd >> {scol[1:0], 1'b0}) & PIX_MASK;
  assign dst_pix    = 2'(frame_rd >> {dcol[1:0], 1'b0}) & PIX_MASK;
  assign gbit       = glyph_rd[3'd7 - scol[2:0]];
  assign glyph_skip = !gbit && !ubg;
  assign last       = (i + 11'd1 == cnt_w) && (j + 11'd1 == cnt_h);

  // Sequencer: next state and strobes.
  always_comb begin
    state_next = state;
    frame_we   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD || in_kind == KIND_NONE || in_w == 11'd0 || in_h == 11'd0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_ADDR;
          end
        end
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: begin
        if (oor) begin
          state_next = last ? ST_DONE : ST_ADDR;
        end else begin
          state_next = ST_USE;
        end
      end
      ST_USE: begin
        if (src_phase && !(op == KIND_GLYPH && glyph_skip)) begin
          state_next = ST_ADDR;
        end else begin
          state_next = last ? ST_DONE : ST_ADDR;
          frame_we   = !src_phase && (op != KIND_READ);
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers stepped by the sequencer.
  logic advance;
  assign advance = (state == ST_READ && oor) ||
                   (state == ST_USE && !(src_phase && !(op == KIND_GLYPH && glyph_skip)));

  always_ff @(posedge clk) begin
    if (rst) begin
      flag      <= 1'b0;
      pv        <= 2'd0;
      src_phase <= 1'b0;
      i         <= 11'd0;
      j         <= 11'd0;
    end else begin
      if (accept) begin
        op        <= in_kind;
        dx        <= x;
        dy        <= y;
        sx        <= src_x;
        sy        <= src_y;
        fg        <= color;
        bg        <= bg_color;
        ubg       <= use_bg;
        cnt_w     <= in_w;
        cnt_h     <= in_h;
        pcol      <= color;
        i         <= 11'd0;
        j         <= 11'd0;
        pv        <= 2'd0;
        src_phase <= (in_kind == KIND_COPY) || (in_kind == KIND_GLYPH);
        flag      <= (in_kind == KIND_LOAD) && !(32'(glyph_addr) < GLYPH_BYTES);
      end
      if (state == ST_ADDR) begin
        addr <= ADDR_W'(prod) + ADDR_W'(mul_off);
      end
      if (state == ST_READ && oor) begin
        flag <= 1'b1;
      end
      if (state == ST_USE) begin
        if (src_phase) begin
          if (op == KIND_GLYPH) begin
            pcol <= gbit ? fg : bg;
          end else begin
            pcol <= src_pix;
          end
        end else if (op == KIND_READ) begin
          pv <= dst_pix;
        end
      end
      if (advance) begin
        src_phase <= (op == KIND_COPY) || (op == KIND_GLYPH);
        if (i + 11'd1 == cnt_w) begin
          i <= 11'd0;
          j <= j + 11'd1;
        end else begin
          i <= i + 11'd1;
        end
      end else if (state == ST_USE) begin
        // The source pixel is in hand; the destination write follows.
        src_phase <= 1'b0;
      end
    end
  end

  assign busy         = (state != ST_IDLE);
  assign done         = (state == ST_DONE);
  assign pixel_value  = pv;
  assign out_of_range = flag;

  `P2PE_ASSERT_NEXT(a_start_busy, accept, busy, "engine not busy after a start transfer")
  `P2PE_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held longer than one cycle")
  `P2PE_ASSERT_NOW(a_write_range, frame_we, addr < ADDR_W'(FRAME_BYTES), "frame write beyond the store")
  `P2PE_ASSERT_NOW(a_pv_zero, done && op != KIND_READ, pixel_value == 2'd0, "pixel value set by a non-read operation")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the packed 2-bit-per-pixel engine.
`timescale 1ns / 1ps

module tb_top;
  import p2pe_pkg::*;

  // One operation as presented on the start port.
  typedef struct {
    kind_t       kind;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [10:0] width;
    logic [10:0] height;
    logic [9:0]  src_x;
    logic [9:0]  src_y;
    logic [1:0]  color;
    logic [1:0]  bg_color;
    logic        use_bg;
    logic [11:0] glyph_addr;
    logic [7:0]  glyph_data;
  } op_t;

  typedef struct {
    logic [1:0] pixel_value;
    logic       out_of_range;
  } answer_t;

  // Shadow copy of both stores and the registers, plus the queue of pending answers.
  class pixel_scoreboard;
    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [7:0]  glyph_mem [GLYPH_BYTES];
    bit          glyph_written [GLYPH_BYTES];
    logic [8:0]  row_pitch = 9'd80;
    logic [8:0]  glyph_pitch = 9'd2;
    logic        xor_on = 1'b0;
    bit          hit_edge;
    answer_t     pending [$];
    int          errors;
    int          checked;

    task report(string what);
      errors++;
      $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ROW_PITCH:   row_pitch = val[8:0];
        REG_GLYPH_PITCH: glyph_pitch = val[8:0];
        REG_XOR_MODE:    xor_on = val[0];
        default: ;
      endcase
    endfunction

    function void put_px(longint col, longint row, logic [1:0] c, bit use_xor);
      longint a;
      int sh;
      a = row * row_pitch + (col >> 2);
      sh = int'(2 * (col & 3));
      if (a >= FRAME_BYTES) begin
        hit_edge = 1;
        return;
      end
      if (use_xor) frame_mem[a] = frame_mem[a] ^ (8'(c) << sh);
      else frame_mem[a] = (frame_mem[a] & ~(8'h03 << sh)) | (8'(c) << sh);
    endfunction

    function bit get_px(longint col, longint row, output logic [1:0] v);
      longint a;
      a = row * row_pitch + (col >> 2);
      v = 2'd0;
      if (a >= FRAME_BYTES) begin
        hit_edge = 1;
        return 0;
      end
      v = 2'(frame_mem[a] >> (2 * (col & 3)));
      return 1;
    endfunction

    // True when every glyph byte inside the store that the operation reads was loaded.
    function bit glyph_ok(op_t op);
      longint a, c;
      for (longint j = 0; j < op.height; j++)
        for (longint i = 0; i < op.width; i++) begin
          c = op.src_x + i;
          a = (op.src_y + j) * glyph_pitch + (c >> 3);
          if (a < GLYPH_BYTES && !glyph_written[a]) return 0;
        end
      return 1;
    endfunction

    // Works out the answer of one accepted operation and queues it.
    function void note(op_t op);
      answer_t ans;
      logic [1:0] v;
      longint a, c;
      bit b;
      hit_edge = 0;
      ans.pixel_value = 2'd0;
      case (op.kind)
        KIND_PLOT: put_px(op.x, op.y, op.color, xor_on);
        KIND_READ: b = get_px(op.x, op.y, ans.pixel_value);
        KIND_HLINE: for (longint i = 0; i < op.width; i++)
          put_px(op.x + i, op.y, op.color, xor_on);
        KIND_VLINE: for (longint j = 0; j < op.height; j++)
          put_px(op.x, op.y + j, op.color, xor_on);
        KIND_COPY: for (longint j = 0; j < op.height; j++)
          for (longint i = 0; i < op.width; i++)
            if (get_px(op.src_x + i, op.src_y + j, v)) put_px(op.x + i, op.y + j, v, 0);
        KIND_GLYPH: for (longint j = 0; j < op.height; j++)
          for (longint i = 0; i < op.width; i++) begin
            c = op.src_x + i;
            a = (op.src_y + j) * glyph_pitch + (c >> 3);
            if (a >= GLYPH_BYTES) hit_edge = 1;
            else if (glyph_mem[a][7 - (c & 7)]) put_px(op.x + i, op.y + j, op.color, 0);
            else if (op.use_bg) put_px(op.x + i, op.y + j, op.bg_color, 0);
          end
        KIND_LOAD: begin
          if (op.glyph_addr < GLYPH_BYTES) begin
            glyph_mem[op.glyph_addr] = op.glyph_data;
            glyph_written[op.glyph_addr] = 1;
          end else hit_edge = 1;
        end
        default: ;
      endcase
      ans.out_of_range = hit_edge;
      pending.push_back(ans);
    endfunction

    task check(logic [1:0] pv, logic oor);
      answer_t want;
      checked++;
      if (pending.size() == 0) begin
        report("answer with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      if (pv !== want.pixel_value)
        report($sformatf("pixel_value %0h, want %0h", pv, want.pixel_value));
      if (oor !== want.out_of_range)
        report($sformatf("out_of_range %0b, want %0b", oor, want.out_of_range));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [9:0]  x = '0, y = '0, src_x = '0, src_y = '0;
  logic [10:0] width = '0, height = '0;
  logic [1:0]  color = '0, bg_color = '0;
  logic        use_bg = 0;
  logic [11:0] glyph_addr = '0;
  logic [7:0]  glyph_data = '0;
  logic        done;
  logic [1:0]  pixel_value;
  logic        out_of_range;

  pixel_scoreboard sb = new();
  int n_sent;

  packed_2bpp_pixel_engine_unit dut (.*);

  always #2 clk = ~clk;

  // Every done cycle carries exactly one answer; the receiver cannot push back.
  always @(posedge clk)
    if (!rst && done) sb.check(pixel_value, out_of_range);

  // Gap length: mostly zero or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Presents one operation, holds it until the start transfer, then idles for the given gap.
  // Called at a falling edge; returns at a falling edge.
  task send_op(op_t op, int gap);
    kind = op.kind; x = op.x; y = op.y; width = op.width; height = op.height;
    src_x = op.src_x; src_y = op.src_y; color = op.color; bg_color = op.bg_color;
    use_bg = op.use_bg; glyph_addr = op.glyph_addr; glyph_data = op.glyph_data;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note(op);
    n_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits until every queued answer has arrived, then lets the engine settle.
  task drain();
    while (sb.pending.size() != 0) @(negedge clk);
    start = 0;
    repeat (8) @(negedge clk);
  endtask

  // One APB write: setup cycle, then access cycle. Only done while the engine is idle.
  task reg_write(logic [1:0] idx, logic [31:0] val);
    drain();
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    @(negedge clk);
  endtask

  function op_t blank_op(kind_t k);
    op_t op;
    op.kind = k; op.x = 0; op.y = 0; op.width = 0; op.height = 0;
    op.src_x = 0; op.src_y = 0; op.color = 0; op.bg_color = 0; op.use_bg = 0;
    op.glyph_addr = 0; op.glyph_data = 0;
    return op;
  endfunction

  // Random operation with random content; sizes stay small except now and then.
  function op_t random_op();
    op_t op;
    bit big;
    op.kind = kind_t'($urandom_range(0, 7));
    op.x = $urandom; op.y = $urandom; op.src_x = $urandom; op.src_y = $urandom;
    op.color = $urandom; op.bg_color = $urandom; op.use_bg = $urandom;
    op.glyph_addr = $urandom; op.glyph_data = $urandom;
    big = ($urandom_range(0, 39) == 0);
    // Keep the y range low most of the time so that writes mostly land inside the store.
    if ($urandom_range(0, 3) != 0) begin
      op.y = $urandom_range(0, 140);
      op.src_y = $urandom_range(0, 140);
    end
    if (op.kind inside {KIND_HLINE, KIND_VLINE}) begin
      op.width = big ? $urandom_range(0, 1024) : $urandom_range(0, 24);
      op.height = big ? $urandom_range(0, 1024) : $urandom_range(0, 24);
      if (big && $urandom_range(0, 1)) begin
        op.width = 1024; op.height = 1024;
      end
    end else if (big) begin
      // A long thin rectangle: one dimension large, the other 0 or 1.
      if ($urandom_range(0, 1)) begin
        op.width = $urandom_range(512, 1024); op.height = $urandom_range(0, 1);
      end else begin
        op.height = $urandom_range(512, 1024); op.width = $urandom_range(0, 1);
      end
    end else begin
      op.width = $urandom_range(0, 8);
      op.height = $urandom_range(0, 8);
    end
    // Glyph sources stay mostly in the loaded low bytes; one that would touch
    // an unloaded byte becomes a load instead.
    if (op.kind == KIND_GLYPH) begin
      if ($urandom_range(0, 3) != 0) begin
        op.src_y = $urandom_range(0, 3);
        op.src_x = $urandom_range(0, 255);
      end
      if (!sb.glyph_ok(op)) op.kind = KIND_LOAD;
    end
    return op;
  endfunction

  initial begin
    op_t op;
    logic [8:0] pitches [6] = '{9'd0, 9'd1, 9'd80, 9'd256, 9'd511, 9'd37};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    repeat (2) @(negedge clk);

    // Fill the frame store and the low glyph bytes first, so that no read touches undefined data.
    reg_write(REG_ROW_PITCH, 256);
    reg_write(REG_XOR_MODE, 0);
    for (int r = 0; r < FRAME_BYTES / 256; r++) begin
      op = blank_op(KIND_HLINE);
      op.y = r; op.width = 1024; op.color = $urandom;
      send_op(op, 0);
    end
    for (int a = 0; a < 256; a++) begin
      op = blank_op(KIND_LOAD);
      op.glyph_addr = a; op.glyph_data = $urandom;
      send_op(op, $urandom_range(0, 1));
    end

    // Directed corner cases.
    reg_write(REG_ROW_PITCH, 80);
    reg_write(REG_GLYPH_PITCH, 2);
    op = blank_op(KIND_PLOT); op.color = 3; send_op(op, 1);
    op = blank_op(KIND_READ); send_op(op, 0);
    op = blank_op(KIND_PLOT); op.x = 1023; op.y = 409; op.color = 2; send_op(op, 0);
    op = blank_op(KIND_READ); op.x = 1023; op.y = 409; send_op(op, 0);
    // Writes and reads past the end of the frame store.
    op = blank_op(KIND_PLOT); op.x = 1023; op.y = 1023; op.color = 1; send_op(op, 0);
    op = blank_op(KIND_READ); op.x = 1023; op.y = 1023; send_op(op, 0);
    // Zero-length lines and empty rectangles.
    op = blank_op(KIND_HLINE); op.x = 5; op.color = 3; send_op(op, 0);
    op = blank_op(KIND_VLINE); op.x = 5; op.color = 3; send_op(op, 0);
    op = blank_op(KIND_COPY); op.width = 5; send_op(op, 0);
    op = blank_op(KIND_GLYPH); op.height = 5; send_op(op, 0);
    // A line that runs past the row end and one that runs off the store.
    op = blank_op(KIND_HLINE); op.x = 300; op.y = 3; op.width = 40; op.color = 2;
    send_op(op, 2);
    op = blank_op(KIND_VLINE); op.x = 7; op.y = 400; op.height = 20; op.color = 1;
    send_op(op, 0);
    // Overlapping copy, shifted right and down by one pixel.
    op = blank_op(KIND_COPY); op.x = 11; op.y = 4; op.src_x = 10; op.src_y = 3;
    op.width = 6; op.height = 4; send_op(op, 0);
    // Copy whose source runs off the store.
    op = blank_op(KIND_COPY); op.x = 0; op.y = 0; op.src_x = 1020; op.src_y = 408;
    op.width = 8; op.height = 3; send_op(op, 0);
    // Glyph expansion with and without background, and one reading past the glyph store.
    op = blank_op(KIND_GLYPH); op.x = 20; op.y = 20; op.src_x = 3; op.src_y = 1;
    op.width = 12; op.height = 3; op.color = 3; op.bg_color = 1; op.use_bg = 1;
    send_op(op, 0);
    op.use_bg = 0; op.x = 40; send_op(op, 0);
    reg_write(REG_GLYPH_PITCH, 256);
    op = blank_op(KIND_GLYPH); op.src_y = 1023; op.src_x = 1023; op.width = 4;
    op.height = 2; op.color = 2; op.use_bg = 1; send_op(op, 0);
    op = blank_op(KIND_LOAD); op.glyph_addr = 4095; op.glyph_data = 8'hff; send_op(op, 0);
    op = blank_op(KIND_NONE); op.x = 10'h3ff; send_op(op, 0);
    // XOR mode on plots and lines.
    reg_write(REG_XOR_MODE, 1);
    op = blank_op(KIND_PLOT); op.color = 3; send_op(op, 0);
    op = blank_op(KIND_READ); send_op(op, 0);
    op = blank_op(KIND_HLINE); op.y = 2; op.width = 9; op.color = 1; send_op(op, 0);
    op = blank_op(KIND_VLINE); op.x = 3; op.height = 9; op.color = 2; send_op(op, 0);

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(REG_ROW_PITCH, 32'(pitches[ph % 6]));
      reg_write(REG_GLYPH_PITCH, 32'(pitches[(ph + 3) % 6]));
      reg_write(REG_XOR_MODE, 32'(ph[0]));
      for (int k = 0; k < 37; k++) begin
        if (ph == 4 && k == 30) drain();
        send_op(random_op(), ($urandom_range(0, 5) == 0) ? 0 : pick_gap());
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.pending.size() != 0) sb.report("answers still outstanding at the end");
    $display("Ran %0d operations, %0d answers checked, across six pitch values and both",
             n_sent, sb.checked);
    $display("draw modes, after filling the frame store and the low glyph bytes.");
    if (sb.errors == 0) $display("[packed_2bpp_pixel_engine_unit] OK");
    else $display("[packed_2bpp_pixel_engine_unit] ERROR");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #40ms;
    $display("[packed_2bpp_pixel_engine_unit] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/p2pe_pkg.sv
rtl/packed_2bpp_pixel_engine_unit.sv
dv/tb_top.sv
